// File: hw/rtl/bm25_pkg.sv
// shared types and constants for the bm25 label score accumulator
package bm25_pkg;

   localparam int SCORE_FRAC_BITS_DEF = 16;
   localparam int WEIGHT_FRAC = 24;
   localparam int LABEL_W = 8;
   localparam int OCCS_W = 16;
   localparam int FLEN_W = 24;
   localparam int WORD_W = 32;
   localparam int NUM_W = OCCS_W + WORD_W;
   localparam int LPROD_W = WORD_W + FLEN_W;
   localparam int DEN_W = LPROD_W + 2;
   localparam int CSR_IDX_W = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [WORD_W-1:0] LENGTH_COEF_RESET = 32'd15099494;
   localparam logic [WORD_W-1:0] LENGTH_BASE_RESET = 32'd5033165;

   localparam logic [CSR_IDX_W-1:0] REG_LENGTH_COEF = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LENGTH_BASE = 8'd1;

   typedef enum logic [1:0] {
      TERM_ZERO,
      TERM_DEGRADED,
      TERM_DIV
   } term_kind_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIV,
      BACK_DONE
   } back_state_type;

   typedef struct packed {
      logic [LABEL_W-1:0] label;
      term_kind_type      kind;
      logic [NUM_W-1:0]   num;
      logic [DEN_W-1:0]   den;
      logic [WORD_W-1:0]  degraded;
      logic               last_label;
      logic               last_doc;
   } entry_type;

endpackage

// File: hw/rtl/bm25_if.sv
// channel interfaces: term input, label result, register write
interface bm25_req_if;
   logic                              valid;
   logic                              ready;
   logic [bm25_pkg::LABEL_W-1:0]      label_index;
   logic                              has_data;
   logic [bm25_pkg::OCCS_W-1:0]       occ_count;
   logic [bm25_pkg::FLEN_W-1:0]       field_length;
   logic [bm25_pkg::WORD_W-1:0]       term_weight;
   logic [bm25_pkg::WORD_W-1:0]       fallback_score;
   logic                              last_of_label;
   logic                              last_of_doc;
   modport source (output valid, label_index, has_data, occ_count, field_length,
                   term_weight, fallback_score, last_of_label, last_of_doc,
                   input ready);
   modport sink (input valid, label_index, has_data, occ_count, field_length,
                 term_weight, fallback_score, last_of_label, last_of_doc,
                 output ready);
endinterface

interface bm25_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [bm25_pkg::LABEL_W-1:0]      label_out;
   logic [bm25_pkg::WORD_W-1:0]       label_score;
   logic                              present;
   logic                              doc_done;
   modport source (output valid, label_out, label_score, present, doc_done,
                   input ready);
   modport sink (input valid, label_out, label_score, present, doc_done,
                 output ready);
endinterface

interface bm25_csr_if;
   logic                              valid;
   logic                              ready;
   logic [bm25_pkg::CSR_IDX_W-1:0]    index;
   logic [bm25_pkg::WORD_W-1:0]       data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/bm25_front.sv
// front end: registers, term classification, numerator and denominator
module bm25_front (
   input  logic                clock,
   input  logic                reset,
   bm25_req_if.sink            req_bus,
   bm25_csr_if.sink            csr_bus,
   input  logic                q_full,
   output logic                q_push,
   output bm25_pkg::entry_type q_entry
);

   logic [bm25_pkg::WORD_W-1:0]  coef_ff, base_ff;
   logic                         valid_ff;
   logic [bm25_pkg::LABEL_W-1:0] label_ff;
   bm25_pkg::term_kind_type      kind_ff, kind_in;
   logic [bm25_pkg::OCCS_W-1:0]  occs_ff;
   logic [bm25_pkg::NUM_W-1:0]   num_ff;
   logic [bm25_pkg::LPROD_W-1:0] lprod_ff;
   logic [bm25_pkg::WORD_W-1:0]  degraded_ff;
   logic                         last_label_ff, last_doc_ff;
   logic                         take;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = !valid_ff || !q_full;
   assign take = req_bus.valid && req_bus.ready;
   assign q_push = valid_ff && !q_full;

   always_comb begin
      if (!req_bus.has_data) begin
         kind_in = bm25_pkg::TERM_ZERO;
      end else if (req_bus.occ_count == '0) begin
         kind_in = bm25_pkg::TERM_DEGRADED;
      end else begin
         kind_in = bm25_pkg::TERM_DIV;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= bm25_pkg::LENGTH_COEF_RESET;
         base_ff <= bm25_pkg::LENGTH_BASE_RESET;
      end else if (csr_bus.valid) begin
         if (csr_bus.index == bm25_pkg::REG_LENGTH_COEF) begin
            coef_ff <= csr_bus.data;
         end else if (csr_bus.index == bm25_pkg::REG_LENGTH_BASE) begin
            base_ff <= csr_bus.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= 1'b1;
      end else if (q_push) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         label_ff      <= req_bus.label_index;
         kind_ff       <= kind_in;
         occs_ff       <= req_bus.occ_count;
         num_ff        <= bm25_pkg::NUM_W'(req_bus.occ_count)
                        * bm25_pkg::NUM_W'(req_bus.term_weight);
         lprod_ff      <= bm25_pkg::LPROD_W'(coef_ff)
                        * bm25_pkg::LPROD_W'(req_bus.field_length);
         degraded_ff   <= req_bus.fallback_score;
         last_label_ff <= req_bus.last_of_label;
         last_doc_ff   <= req_bus.last_of_doc;
      end
   end

   always_comb begin
      q_entry.label      = label_ff;
      q_entry.kind       = kind_ff;
      q_entry.num        = num_ff;
      q_entry.den        = bm25_pkg::DEN_W'({occs_ff, {bm25_pkg::WEIGHT_FRAC{1'b0}}})
                         + bm25_pkg::DEN_W'(base_ff) + bm25_pkg::DEN_W'(lprod_ff);
      q_entry.degraded   = degraded_ff;
      q_entry.last_label = last_label_ff;
      q_entry.last_doc   = last_doc_ff;
   end

endmodule

// File: hw/rtl/bm25_queue.sv
// short fifo of classified terms between front and back
module bm25_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bm25_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output bm25_pkg::entry_type pop_entry
);

   localparam int PTR_W = (bm25_pkg::QUEUE_DEPTH > 1) ? $clog2(bm25_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(bm25_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(bm25_pkg::QUEUE_DEPTH - 1);

   bm25_pkg::entry_type slot_ff [bm25_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [CNT_W-1:0] count_ff;

   assign full = count_ff == CNT_W'(bm25_pkg::QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign pop_entry = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == LAST_PTR) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == LAST_PTR) ? '0 : rd_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

endmodule

// File: hw/rtl/bm25_back.sv
// back end: bit-serial divider, label accumulator and result register
module bm25_back #(
   parameter int SCORE_FRAC_BITS = bm25_pkg::SCORE_FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  bm25_pkg::entry_type q_entry,
   output logic                q_pop,
   bm25_rsp_if.source          rsp_bus
);

   localparam int QW = bm25_pkg::NUM_W + SCORE_FRAC_BITS;
   localparam int CNT_W = $clog2(QW);
   localparam int DW = bm25_pkg::DEN_W;
   localparam int WW = bm25_pkg::WORD_W;

   bm25_pkg::back_state_type state_ff, state_in;
   bm25_pkg::entry_type      work_ff;
   logic [QW-1:0]            shift_ff, quot_ff;
   logic [DW-1:0]            rem_ff;
   logic [CNT_W-1:0]         count_ff;
   logic [WW-1:0]            sum_ff;
   logic                     rsp_valid_ff;
   logic [bm25_pkg::LABEL_W-1:0] rsp_label_ff;
   logic [WW-1:0]            rsp_score_ff;
   logic                     rsp_present_ff, rsp_doc_ff;

   logic [DW:0]   trial;
   logic          fits;
   logic [WW-1:0] term_val;
   logic [WW:0]   sum_wide;
   logic [WW-1:0] sum_sat;
   logic          emit, finish, div_last;

   assign trial = {rem_ff, shift_ff[QW-1]};
   assign fits = trial >= {1'b0, work_ff.den};
   assign div_last = count_ff == CNT_W'(QW - 1);
   assign emit = work_ff.last_label || work_ff.last_doc;

   always_comb begin
      case (work_ff.kind)
         bm25_pkg::TERM_DEGRADED: term_val = work_ff.degraded;
         bm25_pkg::TERM_DIV:
            term_val = (|quot_ff[QW-1:WW]) ? '1 : quot_ff[WW-1:0];
         default: term_val = '0;
      endcase
   end

   assign sum_wide = {1'b0, sum_ff} + {1'b0, term_val};
   assign sum_sat = sum_wide[WW] ? '1 : sum_wide[WW-1:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bm25_pkg::BACK_IDLE: begin
            if (!q_empty) begin
               state_in = (q_entry.kind == bm25_pkg::TERM_DIV) ?
                          bm25_pkg::BACK_DIV : bm25_pkg::BACK_DONE;
            end
         end
         bm25_pkg::BACK_DIV: begin
            if (div_last) begin
               state_in = bm25_pkg::BACK_DONE;
            end
         end
         bm25_pkg::BACK_DONE: begin
            if (finish) begin
               state_in = bm25_pkg::BACK_IDLE;
            end
         end
         default: state_in = bm25_pkg::BACK_IDLE;
      endcase
   end

   always_comb begin
      q_pop  = 1'b0;
      finish = 1'b0;
      unique case (state_ff)
         bm25_pkg::BACK_IDLE: q_pop = !q_empty;
         bm25_pkg::BACK_DIV: ;
         bm25_pkg::BACK_DONE: finish = !emit || !rsp_valid_ff || rsp_bus.ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bm25_pkg::BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // restoring division of num * 2^frac by den, one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (q_pop) begin
         work_ff  <= q_entry;
         shift_ff <= {q_entry.num, {SCORE_FRAC_BITS{1'b0}}};
         quot_ff  <= '0;
         rem_ff   <= '0;
         count_ff <= '0;
      end else if (state_ff == bm25_pkg::BACK_DIV) begin
         shift_ff <= {shift_ff[QW-2:0], 1'b0};
         quot_ff  <= {quot_ff[QW-2:0], fits};
         rem_ff   <= fits ? DW'(trial - {1'b0, work_ff.den}) : trial[DW-1:0];
         count_ff <= count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (finish) begin
            sum_ff <= emit ? '0 : sum_sat;
            if (emit) begin
               rsp_valid_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (finish && emit) begin
         rsp_label_ff   <= work_ff.label;
         rsp_score_ff   <= sum_sat;
         rsp_present_ff <= sum_sat != '0;
         rsp_doc_ff     <= work_ff.last_doc;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.label_out   = rsp_label_ff;
   assign rsp_bus.label_score = rsp_score_ff;
   assign rsp_bus.present     = rsp_present_ff;
   assign rsp_bus.doc_done    = rsp_doc_ff;

endmodule

// File: hw/rtl/bm25_label_score_accumulator.sv
// bm25 label score accumulator: an accepted term passes the front register and a two-entry
// queue; the back end dequeues it, runs 48 + SCORE_FRAC_BITS divider steps for a division
// term, then accumulates, waiting in its done state while an earlier result is not taken;
// the front register and the queue take new terms meanwhile
// synchronous active-high reset clears the sum, queue and result valid and
// restores length_coef and length_base to their defaults
module bm25_label_score_accumulator #(
   parameter int SCORE_FRAC_BITS = bm25_pkg::SCORE_FRAC_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   bm25_req_if.sink   req_bus,
   bm25_rsp_if.source rsp_bus,
   bm25_csr_if.sink   csr_bus
);

   logic                q_push, q_pop, q_full, q_empty;
   bm25_pkg::entry_type push_entry, pop_entry;

   bm25_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .csr_bus (csr_bus),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_entry (push_entry)
   );

   bm25_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .pop_entry  (pop_entry)
   );

   bm25_back #(
      .SCORE_FRAC_BITS (SCORE_FRAC_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_entry (pop_entry),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule

// File: tb/bm25_label_score_accumulator_test.sv
// self-checking testbench for the bm25 label score accumulator
module bm25_label_score_accumulator_test;

   localparam int LIMIT_CYCLES = 3000000;
   // four division terms may still be in flight after the last result
   localparam int DRAIN_CYCLES = 320;

   typedef struct {
      logic [bm25_pkg::LABEL_W-1:0] label;
      logic                         has_data;
      logic [bm25_pkg::OCCS_W-1:0]  occs;
      logic [bm25_pkg::FLEN_W-1:0]  flen;
      logic [bm25_pkg::WORD_W-1:0]  weight;
      logic [bm25_pkg::WORD_W-1:0]  degraded;
      logic                         last_label;
      logic                         last_doc;
   } term_type;

   typedef struct {
      logic [bm25_pkg::LABEL_W-1:0] label;
      logic [bm25_pkg::WORD_W-1:0]  score;
      logic                         present;
      logic                         doc_done;
   } label_sum_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bm25_req_if req_bus ();
   bm25_rsp_if rsp_bus ();
   bm25_csr_if csr_bus ();

   bm25_label_score_accumulator DUT (
      .clock(clock), .reset(reset),
      .req_bus(req_bus), .rsp_bus(rsp_bus), .csr_bus(csr_bus)
   );

   always #4 clock = ~clock;

   // predictor state
   logic [bm25_pkg::WORD_W-1:0] coef_q = bm25_pkg::LENGTH_COEF_RESET;
   logic [bm25_pkg::WORD_W-1:0] base_q = bm25_pkg::LENGTH_BASE_RESET;
   logic [bm25_pkg::WORD_W-1:0] sum_q  = '0;
   label_sum_type               pending_sums[$];

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  recv_hold     = 0;
   int  errors        = 0;
   int  cycles        = 0;

   function automatic logic [bm25_pkg::WORD_W-1:0] predict_term(term_type t);
      bit [63:0] num, den, q;
      if (!t.has_data) return '0;
      if (t.occs == 0) return t.degraded;
      num = 64'(t.occs) * 64'(t.weight);
      den = (64'(t.occs) << bm25_pkg::WEIGHT_FRAC) + 64'(base_q)
          + 64'(coef_q) * 64'(t.flen);
      q = (num << bm25_pkg::SCORE_FRAC_BITS_DEF) / den;
      return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
   endfunction

   task automatic accumulate_term(term_type t);
      bit [32:0] s;
      label_sum_type r;
      s = 33'(sum_q) + 33'(predict_term(t));
      sum_q = s[32] ? 32'hFFFF_FFFF : s[31:0];
      if (t.last_label || t.last_doc) begin
         r.label = t.label;
         r.score = sum_q;
         r.present = (sum_q != 0);
         r.doc_done = t.last_doc;
         pending_sums.insert(pending_sums.size(), r);
         sum_q = '0;
      end
   endtask

   task automatic send_term(term_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.label_index    <= t.label;
      req_bus.has_data       <= t.has_data;
      req_bus.occ_count      <= t.occs;
      req_bus.field_length   <= t.flen;
      req_bus.term_weight    <= t.weight;
      req_bus.fallback_score <= t.degraded;
      req_bus.last_of_label  <= t.last_label;
      req_bus.last_of_doc    <= t.last_doc;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      accumulate_term(t);
   endtask

   task automatic stop_sending();
      req_bus.valid <= 1'b0;
   endtask

   task automatic wait_idle();
      stop_sending();
      @(posedge clock);
      while (pending_sums.size() != 0) @(posedge clock);
      // terms without a result may still be in the divider
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [bm25_pkg::CSR_IDX_W-1:0] idx,
                            logic [bm25_pkg::WORD_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      if (idx == bm25_pkg::REG_LENGTH_COEF) coef_q = value;
      else if (idx == bm25_pkg::REG_LENGTH_BASE) base_q = value;
   endtask

   task automatic set_params(logic [bm25_pkg::WORD_W-1:0] coef,
                             logic [bm25_pkg::WORD_W-1:0] base);
      wait_idle();
      write_reg(bm25_pkg::REG_LENGTH_COEF, coef);
      write_reg(bm25_pkg::REG_LENGTH_BASE, base);
   endtask

   function automatic term_type make_term(logic [bm25_pkg::LABEL_W-1:0] label, logic hd,
                                          logic [bm25_pkg::OCCS_W-1:0] occs,
                                          logic [bm25_pkg::FLEN_W-1:0] flen,
                                          logic [bm25_pkg::WORD_W-1:0] w,
                                          logic [bm25_pkg::WORD_W-1:0] deg,
                                          logic ll, logic ld);
      term_type t;
      t.label = label; t.has_data = hd; t.occs = occs; t.flen = flen;
      t.weight = w; t.degraded = deg; t.last_label = ll; t.last_doc = ld;
      return t;
   endfunction

   function automatic term_type random_term();
      term_type t;
      t.label    = bm25_pkg::LABEL_W'($urandom_range(255));
      t.has_data = ($urandom_range(9) != 0);
      case ($urandom_range(3))
         0: t.occs = '0;
         1: t.occs = bm25_pkg::OCCS_W'($urandom_range(65535));
         default: t.occs = bm25_pkg::OCCS_W'($urandom_range(1, 8));
      endcase
      t.flen     = ($urandom_range(3) == 0) ? bm25_pkg::FLEN_W'($urandom_range(24'hFFFFFF))
                                            : bm25_pkg::FLEN_W'($urandom_range(400));
      t.weight   = $urandom;
      // big fallback scores now and then so sums saturate
      t.degraded = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0010_0000);
      t.last_label = 1'b0;
      t.last_doc   = 1'b0;
      return t;
   endfunction

   // one well-formed label of 1 to 6 terms
   task automatic send_label(input logic end_doc, output int n);
      logic [bm25_pkg::LABEL_W-1:0] label;
      term_type t;
      n = int'($urandom_range(1, 6));
      label = bm25_pkg::LABEL_W'($urandom_range(255));
      for (int i = 0; i < n; i++) begin
         t = random_term();
         t.label = label;
         t.last_label = (i == n - 1);
         t.last_doc = end_doc && (i == n - 1);
         send_term(t);
      end
   endtask

   task automatic send_random_phase(int items);
      int sent;
      int n;
      term_type t;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(9) < 8) begin
            for (int l = $urandom_range(1, 4); l > 0; l--) begin
               send_label(l == 1, n);
               sent += n;
            end
         end else begin
            // noise: random end flags, changing labels
            t = random_term();
            t.last_label = 1'($urandom_range(1));
            t.last_doc = ($urandom_range(3) == 0);
            send_term(t);
            sent++;
         end
      end
   endtask

   task automatic test_reset_defaults();
      send_term(make_term(8'd3, 1'b1, 16'd1, 24'd1, 32'h0100_0000, 32'd0, 1'b1, 1'b0));
      send_term(make_term(8'd4, 1'b1, 16'd2, 24'd10, 32'h0200_0000, 32'd0, 1'b0, 1'b0));
      send_term(make_term(8'd4, 1'b1, 16'd3, 24'd20, 32'h0300_0000, 32'd0, 1'b1, 1'b1));
   endtask

   task automatic test_field_extremes();
      // no ranking data gives zero, label not present
      send_term(make_term(8'd0, 1'b0, 16'hFFFF, 24'hFFFFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 1'b1, 1'b0));
      // degraded score when occurrences are missing
      send_term(make_term(8'hFF, 1'b1, 16'd0, 24'd0, 32'd0, 32'h1234_5678, 1'b1, 1'b0));
      send_term(make_term(8'h80, 1'b1, 16'hFFFF, 24'd0, 32'hFFFF_FFFF, 32'd0, 1'b1, 1'b0));
      send_term(make_term(8'h7F, 1'b1, 16'd1, 24'hFFFFFF, 32'hFFFF_FFFF, 32'd0, 1'b1, 1'b0));
      send_term(make_term(8'h55, 1'b1, 16'd1, 24'd0, 32'd0, 32'd0, 1'b1, 1'b0));
      // sum saturation
      send_term(make_term(8'h11, 1'b1, 16'd0, 24'd0, 32'd0, 32'hFFFF_FFF0, 1'b0, 1'b0));
      send_term(make_term(8'h11, 1'b1, 16'd0, 24'd0, 32'd0, 32'h0000_0100, 1'b0, 1'b0));
      send_term(make_term(8'h11, 1'b1, 16'd5, 24'd3, 32'h0500_0000, 32'd0, 1'b1, 1'b0));
      // document end without label end, with label index changing inside
      send_term(make_term(8'h21, 1'b1, 16'd4, 24'd7, 32'h0A00_0000, 32'd0, 1'b0, 1'b0));
      send_term(make_term(8'h22, 1'b1, 16'd0, 24'd7, 32'd0, 32'd77, 1'b0, 1'b1));
      send_term(make_term(8'hAA, 1'b1, 16'h5555, 24'hAAAAAA, 32'h5555_5555,
                          32'hAAAA_AAAA, 1'b1, 1'b1));
   endtask

   task automatic test_param_extremes();
      set_params(32'd0, 32'd0);
      test_field_extremes();
      set_params(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      test_field_extremes();
      set_params(32'h5555_5555, 32'hAAAA_AAAA);
      test_reset_defaults();
      set_params(bm25_pkg::LENGTH_COEF_RESET, bm25_pkg::LENGTH_BASE_RESET);
   endtask

   task automatic test_random_traffic();
      send_idle_pct = 9;  recv_idle_pct = 54;
      send_random_phase(380);
      set_params($urandom_range(32'h0200_0000), $urandom_range(32'h0100_0000));
      send_idle_pct = 54; recv_idle_pct = 9;
      send_random_phase(380);
      set_params($urandom, $urandom);
      send_idle_pct = 0;  recv_idle_pct = 0;
      send_random_phase(320);
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;  recv_idle_pct = 0;
      recv_hold = 600;
      send_random_phase(30);
   endtask

   // receiver: random stalls plus long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (recv_hold > 0) begin
         recv_hold <= recv_hold - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      label_sum_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_sums.size() == 0) begin
            $display("%0t: unexpected result beat label=%0d score=%h", $time,
                     rsp_bus.label_out, rsp_bus.label_score);
            errors++;
         end else begin
            e = pending_sums.pop_front();
            if (rsp_bus.label_out !== e.label) begin
               $display("%0t: label_out expected %0d actual %0d", $time, e.label,
                        rsp_bus.label_out);
               errors++;
            end
            if (rsp_bus.label_score !== e.score) begin
               $display("%0t: label_score expected %h actual %h", $time, e.score,
                        rsp_bus.label_score);
               errors++;
            end
            if (rsp_bus.present !== e.present) begin
               $display("%0t: present expected %b actual %b", $time, e.present,
                        rsp_bus.present);
               errors++;
            end
            if (rsp_bus.doc_done !== e.doc_done) begin
               $display("%0t: doc_done expected %b actual %b", $time, e.doc_done,
                        rsp_bus.doc_done);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("bm25_label_score_accumulator_test: FAIL");
         $finish;
      end
   end

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.label_index <= '0;
      req_bus.has_data <= 1'b0;
      req_bus.occ_count <= '0;
      req_bus.field_length <= '0;
      req_bus.term_weight <= '0;
      req_bus.fallback_score <= '0;
      req_bus.last_of_label <= 1'b0;
      req_bus.last_of_doc <= 1'b0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= '0;
      csr_bus.data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_field_extremes();
      test_param_extremes();
      test_backpressure();
      test_random_traffic();
      wait_idle();
      if (errors == 0 && pending_sums.size() == 0)
         $display("bm25_label_score_accumulator_test: PASS");
      else
         $display("bm25_label_score_accumulator_test: FAIL");
      $finish;
   end

endmodule
